>>> rtl/avs_pkg.sv
// Shared constants and types for the Anscombe variance stabilizer.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package avs_pkg;

	// pixel format
	localparam int PIXEL_BITS = 16;
	localparam logic [15:0] PIX_MAX = 16'((1 << PIXEL_BITS) - 1);

	// native scheme: gain 1.0 (Q8.16), offset 3/8 (Q20.12)
	localparam logic [23:0] NATIVE_GAIN = 24'd65536;
	localparam logic [31:0] NATIVE_OFFSET = 32'd1536;

	// register indexes on the configuration channel
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_DIRECTION = 3'd1;
	localparam logic [2:0] REG_GAIN = 3'd2;
	localparam logic [2:0] REG_OFFSET = 3'd3;
	localparam logic [2:0] REG_INV_GAIN = 3'd4;

	// mode codes; the unused code behaves as pass through
	localparam logic [1:0] MODE_PASS = 2'd0;
	localparam logic [1:0] MODE_NATIVE = 2'd1;
	localparam logic [1:0] MODE_GEN = 2'd2;

	// direction codes
	localparam logic DIR_FWD = 1'b0;
	localparam logic DIR_INV = 1'b1;

	// effective transform coefficients after mode selection
	typedef struct packed {
		logic        dir;
		logic [23:0] gain;
		logic [31:0] offset;
		logic [23:0] inv_gain;
	} avs_coef_t;

	// front end result: radicand for forward, difference for inverse
	typedef struct packed {
		logic [15:0] x;
		logic [28:0] rad;
		logic [41:0] diff;
		logic        neg;
	} avs_front_t;

	// square root pipeline word: remaining radicand, partial remainder, root
	typedef struct packed {
		logic [29:0] rad;
		logic [16:0] rem;
		logic [14:0] root;
	} avs_sqrt_t;

endpackage

`default_nettype wire

>>> rtl/anscombe_variance_stabilizer_top.sv
// Anscombe variance stabilizer, top level: config registers, valid pipeline,
// output stage. Depends on avs_pkg, avs_front, avs_sqrt_stage and avs_inv.
//
// Usage:
//   s_* is the sample input stream, m_* the result stream, 16-bit samples in
//   tdata. cfg_* writes one register per request (index 0 mode, 1 direction,
//   2 gain, 3 offset, 4 inverse gain); cfg_ready is always high and other
//   indexes are dropped. Write registers only while no sample is in flight.
//   Eight register stages; stage 1 loads at the input accepting edge, and
//   m_tvalid rises once that sample is in the stage 8 output register.
//   Throughput is one sample per clock unless stalled: stage 1 multiply,
//   stage 2 offset, stages 3 to 7 the square root (three digits per stage)
//   beside the inverse product, round and clamp, stage 8 the output register.
//   Reset (arst_n low) empties the pipeline and loads the native defaults
//   into the registers with mode pass through.
//   When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module anscombe_variance_stabilizer_top
	import avs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream; s_tdata[15:0] sample_in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,
	// output stream; m_tdata[15:0] sample_out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [1:0]  mode_q;
	logic        dir_q;
	logic [23:0] gain_q;
	logic [31:0] offset_q;
	logic [23:0] inv_gain_q;
	logic [7:0]  vld_q;
	logic        en;
	logic        pass;
	avs_coef_t   coef;
	avs_front_t  front_s2;
	avs_sqrt_t   sq_w [0:5];
	logic [15:0] x_dly_q [3:7];
	logic [15:0] y_inv;
	logic [15:0] x_in;
	logic [15:0] fwd_n;
	logic [15:0] dout_s8;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PASS;
			dir_q <= DIR_FWD;
			gain_q <= NATIVE_GAIN;
			offset_q <= NATIVE_OFFSET;
			inv_gain_q <= NATIVE_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[1:0];
				REG_DIRECTION: dir_q <= cfg_data[0];
				REG_GAIN: gain_q <= cfg_data[23:0];
				REG_OFFSET: offset_q <= cfg_data;
				REG_INV_GAIN: inv_gain_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// coefficient selection by mode
	always_comb begin
		coef.dir = dir_q;
		coef.gain = NATIVE_GAIN;
		coef.offset = NATIVE_OFFSET;
		coef.inv_gain = NATIVE_GAIN;
		pass = 1'b0;
		case (mode_q)
			MODE_NATIVE: ;
			MODE_GEN: begin
				coef.gain = gain_q;
				coef.offset = offset_q;
				coef.inv_gain = inv_gain_q;
			end
			default: pass = 1'b1;
		endcase
	end

	// global advance: move when the output register is free or being taken
	assign en = !vld_q[7] || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 8'd0;
		end else if (en) begin
			vld_q <= {vld_q[6:0], s_tvalid};
		end
	end

	assign x_in = s_tdata & PIX_MAX;

	avs_front u_front (
		.clk      (clk),
		.en       (en),
		.x        (x_in),
		.coef     (coef),
		.front_s2 (front_s2)
	);

	// square root over stages 3 to 7
	assign sq_w[0] = '{rad: {1'b0, front_s2.rad}, rem: 17'd0, root: 15'd0};

	for (genvar k = 0; k < 5; k++) begin : g_sqrt
		avs_sqrt_stage u_stage (
			.clk    (clk),
			.en     (en),
			.din    (sq_w[k]),
			.dout_s (sq_w[k+1])
		);
	end

	avs_inv u_inv (
		.clk      (clk),
		.en       (en),
		.diff     (front_s2.diff),
		.neg      (front_s2.neg),
		.inv_gain (coef.inv_gain),
		.y_s7     (y_inv)
	);

	// pass-through sample delay line
	always_ff @(posedge clk) begin
		if (en) begin
			x_dly_q[3] <= front_s2.x;
			for (int i = 4; i <= 7; i++) begin
				x_dly_q[i] <= x_dly_q[i-1];
			end
		end
	end

	// forward rounding: n = (floor sqrt + 1) / 2
	assign fwd_n = ({1'b0, sq_w[5].root} + 16'd1) >> 1;

	// stage 8: output select and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			if (pass) begin
				dout_s8 <= x_dly_q[7];
			end else if (dir_q == DIR_INV) begin
				dout_s8 <= y_inv;
			end else if (fwd_n > PIX_MAX) begin
				dout_s8 <= PIX_MAX;
			end else begin
				dout_s8 <= fwd_n;
			end
		end
	end

	assign m_tvalid = vld_q[7];
	assign m_tdata = dout_s8;

endmodule

`default_nettype wire

>>> rtl/avs_front.sv
// Front end, stages 1 and 2: one shared multiplier, then offset add/subtract.
// Depends on avs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avs_front
	import avs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       en,
	input  wire logic [15:0] x,
	input  wire avs_coef_t  coef,
	output avs_front_t      front_s2
);

	logic [15:0] x_s1;
	logic [39:0] prod_s1;
	logic [23:0] mul_b;
	logic [39:0] prod;
	logic [40:0] vsum;
	logic [41:0] sq;
	logic [41:0] cext;

	// forward multiplies by the gain, inverse squares the sample
	assign mul_b = (coef.dir == DIR_INV) ? {8'd0, x} : coef.gain;
	assign prod = 40'(x) * 40'(mul_b);

	// stage 1: product
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			prod_s1 <= prod;
		end
	end

	// forward: g*x + c in Q16; inverse: x^2/4 in Q12 against c
	assign vsum = {1'b0, prod_s1} + {5'd0, coef.offset, 4'd0};
	assign sq = {prod_s1[31:0], 10'd0};
	assign cext = {10'd0, coef.offset};

	// stage 2
	always_ff @(posedge clk) begin
		if (en) begin
			front_s2.x <= x_s1;
			front_s2.rad <= vsum[40:12];
			front_s2.diff <= sq - cext;
			front_s2.neg <= (sq <= cext);
		end
	end

endmodule

`default_nettype wire

>>> rtl/avs_sqrt_stage.sv
// One registered stage of the integer square root: three digit steps.
// Depends on avs_pkg; five instances make the full 15-bit root.
`timescale 1ns / 1ps
`default_nettype none

module avs_sqrt_stage
	import avs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      en,
	input  wire avs_sqrt_t din,
	output avs_sqrt_t      dout_s
);

	avs_sqrt_t nxt;

	// restoring digit recurrence, two radicand bits per step
	always_comb begin
		logic [18:0] trem;
		logic [18:0] trial;
		nxt = din;
		for (int i = 0; i < 3; i++) begin
			trem = {nxt.rem, nxt.rad[29:28]};
			trial = {2'd0, nxt.root, 2'b01};
			nxt.rad = {nxt.rad[27:0], 2'b00};
			if (trem >= trial) begin
				nxt.rem = 17'(trem - trial);
				nxt.root = {nxt.root[13:0], 1'b1};
			end else begin
				nxt.rem = trem[16:0];
				nxt.root = {nxt.root[13:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_s <= nxt;
		end
	end

endmodule

`default_nettype wire

>>> rtl/avs_inv.sv
// Inverse path, stages 3 to 7: split product by inverse gain, sum, round,
// saturate, then delay to line up with the square root. Depends on avs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avs_inv
	import avs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [41:0] diff,
	input  wire logic        neg,
	input  wire logic [23:0] inv_gain,
	output logic [15:0]      y_s7
);

	localparam logic [65:0] SAT_LIMIT = ((66'(PIX_MAX) << 1) + 66'd1) << 27;
	localparam logic [65:0] HALF_LSB = 66'd1 << 27;

	logic [44:0] plo_s3;
	logic [44:0] phi_s3;
	logic        zero_s3;
	logic [65:0] prod_s4;
	logic        zero_s4;
	logic [15:0] y_s5;
	logic [15:0] y_s6;
	logic [65:0] rnd;

	// stage 3: two 21x24 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			plo_s3 <= 45'(diff[20:0]) * 45'(inv_gain);
			phi_s3 <= 45'(diff[41:21]) * 45'(inv_gain);
			zero_s3 <= neg || (inv_gain == 24'd0);
		end
	end

	// stage 4: full Q28 product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= {phi_s3, 21'd0} + {21'd0, plo_s3};
			zero_s4 <= zero_s3;
		end
	end

	// stage 5: round half up and clamp
	assign rnd = prod_s4 + HALF_LSB;

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s4) begin
				y_s5 <= 16'd0;
			end else if (prod_s4 >= SAT_LIMIT) begin
				y_s5 <= PIX_MAX;
			end else begin
				y_s5 <= rnd[43:28];
			end
		end
	end

	// stages 6 and 7: alignment
	always_ff @(posedge clk) begin
		if (en) begin
			y_s6 <= y_s5;
			y_s7 <= y_s6;
		end
	end

endmodule

`default_nettype wire
